// ===== src/tgft_pkg.sv =====
// Package for the temperature glitch filter and trend detector.
// Holds the widths, sizes, register indexes and the result queue entry type.
// Depends on nothing.
`timescale 1ns / 1ps

package tgft_pkg;

   localparam int SLOTS_PER_DAY = 1440;
   localparam int FRACTION_BITS = 8;

   localparam int RAW_W      = 10;
   localparam int MINUTE_W   = 11;
   localparam int SHIFT_W    = 4;
   localparam int LIMIT_W    = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam int SLOT_W     = $clog2(SLOTS_PER_DAY);
   localparam int VALUE_W    = RAW_W + FRACTION_BITS;
   localparam int ACC_W      = VALUE_W + (2 ** SHIFT_W);

   localparam logic [RAW_W-1:0] RAW_MAX = RAW_W'(999);

   localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RESET   = LIMIT_W'(50);
   localparam logic [SHIFT_W-1:0] FILTER_SHIFT_RESET = SHIFT_W'(4);

   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_LIMIT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_SHIFT = CSR_IDX_W'(1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [MINUTE_W-1:0] minute;
      logic [VALUE_W-1:0]  value;
      logic                ac_on;
      logic                last;
   } rsp_entry_type;

endpackage

// ===== src/temperature_glitch_filter_trend.sv =====
// Top level of the temperature glitch filter and air-conditioner trend detector.
// Depends on tgft_pkg for widths, register indexes and the result queue entry.
`timescale 1ns / 1ps

// One input transfer per minute slot: a present flag, a raw reading in tenths
// (clamped to 999) and an end-of-day mark. A present reading is valid when the
// slot before it was invalid or when it moved by less than jump_limit from the
// last raw reading. Valid runs feed a restarting low-pass filter
// f = (f_prev*(2^k-1) + x) >> k with k = filter_shift, kept in tenths with
// FRACTION_BITS fraction bits. The AC rule needs one slot of lookahead, so each
// valid slot is reported when the next slot arrives; the end-of-day slot (or
// the last slot of a day that overruns) flushes the held slot and itself, so
// that transfer gives up to two results; the last result of every transfer carries rsp_last.
// Invalid or missing slots give no result. All per-item work is shift-add
// logic on the registered state, and a request is taken in every
// cycle while the four-entry result queue has room for two more results; the
// rate is one item per cycle as long as the result side drains one result per
// cycle. Configuration writes are always ready and take effect at once; write
// them only while the block is idle.
module temperature_glitch_filter_trend (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_present,
   input  logic [tgft_pkg::RAW_W-1:0]       req_temperature,
   input  logic                             req_end_of_day,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tgft_pkg::MINUTE_W-1:0]    rsp_minute,
   output logic [tgft_pkg::VALUE_W-1:0]     rsp_filtered_temperature,
   output logic                             rsp_ac_on,
   output logic                             rsp_last,
   // configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tgft_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tgft_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tgft_pkg::*;

   // configuration registers
   logic [LIMIT_W-1:0] jump_limit_ff;
   logic [SHIFT_W-1:0] filter_shift_ff;

   // per-day state
   logic [SLOT_W-1:0]  slot_ff,        slot_in;
   logic [RAW_W-1:0]   prev_raw_ff,    prev_raw_in;
   logic               pend_held_ff,   pend_held_in;
   logic               pend_valid_ff,  pend_valid_in;
   logic [VALUE_W-1:0] pend_value_ff,  pend_value_in;
   logic               bef_valid_ff,   bef_valid_in;
   logic [VALUE_W-1:0] bef_value_ff,   bef_value_in;
   logic               bef_status_ff,  bef_status_in;

   // result queue
   rsp_entry_type      queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;

   // combinational working signals
   logic               take_req;
   logic               take_rsp;
   logic               eod;
   logic [RAW_W-1:0]   x_clamped;
   logic [VALUE_W-1:0] x_scaled;
   logic [RAW_W-1:0]   diff;
   logic               new_valid;
   logic [ACC_W-1:0]   acc;
   logic [VALUE_W-1:0] new_filt;
   logic               pend_on;
   logic               eod_on;
   logic               emit_pend;
   logic               emit_eod;
   rsp_entry_type      pend_entry;
   rsp_entry_type      eod_entry;
   rsp_entry_type      push_a;
   logic [1:0]         push_cnt;

   assign csr_ready = 1'b1;

   // Stall when the queue cannot absorb the two results of an end-of-day slot.
   assign req_stall = (count_ff > QCNT_W'(QUEUE_DEPTH - 2));
   assign take_req  = req_valid && !req_stall;

   assign rsp_valid                = (count_ff != '0);
   assign take_rsp                 = rsp_valid && !rsp_stall;
   assign rsp_minute               = queue_ff[rd_ptr_ff].minute;
   assign rsp_filtered_temperature = queue_ff[rd_ptr_ff].value;
   assign rsp_ac_on                = queue_ff[rd_ptr_ff].ac_on;
   assign rsp_last                 = queue_ff[rd_ptr_ff].last;

   always_comb begin
      // Clamp the reading and judge it against the last raw reading.
      x_clamped = (req_temperature > RAW_MAX) ? RAW_MAX : req_temperature;
      x_scaled  = {x_clamped, {FRACTION_BITS{1'b0}}};
      diff      = (x_clamped >= prev_raw_ff) ? (x_clamped - prev_raw_ff)
                                             : (prev_raw_ff - x_clamped);
      new_valid = req_present && (!pend_valid_ff || (diff < jump_limit_ff));
      eod       = req_end_of_day || (slot_ff >= SLOT_W'(SLOTS_PER_DAY - 1));

      // Filter step: f*(2^k-1) as (f << k) - f, add the new sample, scale down.
      acc = ((ACC_W'(pend_value_ff) << filter_shift_ff) - ACC_W'(pend_value_ff))
            + ACC_W'(x_scaled);
      new_filt = pend_valid_ff ? VALUE_W'(acc >> filter_shift_ff) : x_scaled;

      // Judge the held slot now that its lookahead is here.
      pend_on = 1'b0;
      if (pend_valid_ff && bef_valid_ff) begin
         if (bef_status_ff) begin
            pend_on = (pend_value_ff <= bef_value_ff);
         end else begin
            pend_on = (pend_value_ff < bef_value_ff) && new_valid
                      && (new_filt < pend_value_ff);
         end
      end
      emit_pend = pend_held_ff && pend_valid_ff;

      // The slot before the new pending one.
      if (pend_held_ff) begin
         bef_valid_in  = pend_valid_ff;
         bef_value_in  = pend_value_ff;
         bef_status_in = pend_on;
      end else begin
         bef_valid_in  = 1'b0;
         bef_value_in  = '0;
         bef_status_in = 1'b0;
      end

      // End of day: judge the current slot with an invalid lookahead.
      eod_on   = new_valid && bef_valid_in && bef_status_in && (new_filt <= bef_value_in);
      emit_eod = eod && new_valid;

      pend_entry.minute = MINUTE_W'(slot_ff - SLOT_W'(1));
      pend_entry.value  = pend_value_ff;
      pend_entry.ac_on  = pend_on;
      pend_entry.last   = !emit_eod;

      eod_entry.minute  = MINUTE_W'(slot_ff);
      eod_entry.value   = new_filt;
      eod_entry.ac_on   = eod_on;
      eod_entry.last    = 1'b1;

      push_a   = emit_pend ? pend_entry : eod_entry;
      push_cnt = 2'(emit_pend) + 2'(emit_eod);

      prev_raw_in   = req_present ? x_clamped : prev_raw_ff;
      pend_held_in  = 1'b1;
      pend_valid_in = new_valid;
      pend_value_in = new_valid ? new_filt : '0;
      slot_in       = slot_ff + SLOT_W'(1);

      // Flush: drop the whole day back to reset state.
      if (eod) begin
         slot_in       = '0;
         prev_raw_in   = '0;
         pend_held_in  = 1'b0;
         pend_valid_in = 1'b0;
         pend_value_in = '0;
         bef_valid_in  = 1'b0;
         bef_value_in  = '0;
         bef_status_in = 1'b0;
      end

      // Advance the queue pointers.
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (take_req) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
         count_in  = count_ff + QCNT_W'(push_cnt);
      end
      rd_ptr_in = rd_ptr_ff;
      if (take_rsp) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
         count_in  = count_in - QCNT_W'(1);
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         jump_limit_ff   <= JUMP_LIMIT_RESET;
         filter_shift_ff <= FILTER_SHIFT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_JUMP_LIMIT:   jump_limit_ff   <= csr_data[LIMIT_W-1:0];
            CSR_FILTER_SHIFT: filter_shift_ff <= csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // Per-day state, updated on every request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         prev_raw_ff   <= '0;
         pend_held_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_value_ff <= '0;
         bef_valid_ff  <= 1'b0;
         bef_value_ff  <= '0;
         bef_status_ff <= 1'b0;
      end else if (take_req) begin
         slot_ff       <= slot_in;
         prev_raw_ff   <= prev_raw_in;
         pend_held_ff  <= pend_held_in;
         pend_valid_ff <= pend_valid_in;
         pend_value_ff <= pend_value_in;
         bef_valid_ff  <= bef_valid_in;
         bef_value_ff  <= bef_value_in;
         bef_status_ff <= bef_status_in;
      end
   end

   // Queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue payload: hold up to two new results per transfer.
   always_ff @(posedge clock) begin
      if (take_req && (push_cnt != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= push_a;
      end
      if (take_req && (push_cnt == 2'd2)) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= eod_entry;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_eod_clears: assert property (@(posedge clock) disable iff (reset)
      (take_req && req_end_of_day) |=> (slot_ff == '0) && !pend_held_ff && !bef_valid_ff)
      else $error("end of day did not restart the day state");

   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      (take_req && !eod) |=> (slot_ff == $past(slot_ff) + SLOT_W'(1)))
      else $error("slot counter did not advance");

   a_held_after_item: assert property (@(posedge clock) disable iff (reset)
      (take_req && !eod) |=> pend_held_ff)
      else $error("slot not held after a transfer");

endmodule
